[rtl/ssa_pkg.sv]
package ssa_pkg;

   localparam int CMD_W  = 1;
   localparam int SLAB_W = 6;
   localparam int SLOT_W = 6;
   localparam int STAT_W = 2;
   localparam int CFG_W  = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLAB_W-1:0] item_slab;
      logic [SLOT_W-1:0] item_slot;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLAB_W-1:0] got_slab;
      logic [SLOT_W-1:0] got_slot;
   } rsp_payload_type;

endpackage

[rtl/ssa_channels.sv]
interface ssa_req_if;
   logic                     valid;
   logic                     ready;
   ssa_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssa_rsp_if;
   logic                     valid;
   logic                     ready;
   ssa_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ssa_pkg::CFG_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/slab_slot_allocator.sv]
// A request beat is captured in S_IDLE and executed in S_EX; the result is
// registered in S_PUT, after link write-backs in S_W1 and S_W2 when a slab
// moves between lists. One request at a time, set by the single write port
// of the link memories. Next request is taken while a result waits.
// Reset and every csr write start a clearing pass over all NUM_SLABS slabs that
// rebuilds the pool; no request is taken during it.
module slab_slot_allocator #(
   parameter int NUM_SLABS = 64,
   parameter int MAX_SLOTS = 64
) (
   input  logic      clock,
   input  logic      reset,
   ssa_req_if.sink   req_ch,
   ssa_rsp_if.source rsp_ch,
   ssa_csr_if.sink   csr_ch
);

   localparam int IW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int LW = IW + 1;
   localparam int MW = MAX_SLOTS;
   localparam int CW = ssa_pkg::CFG_W;
   localparam logic [LW-1:0] NIL = LW'(NUM_SLABS);

   // list codes
   localparam logic [1:0] L_PART  = 2'd0;
   localparam logic [1:0] L_EMPTY = 2'd1;
   localparam logic [1:0] L_FULL  = 2'd2;

   typedef enum logic [2:0] {S_INIT, S_IDLE, S_EX, S_W1, S_W2, S_PUT} state_type;

   // memories
   logic [MW-1:0] mask_mem [NUM_SLABS];
   logic [LW-1:0] next_mem [NUM_SLABS];
   logic [LW-1:0] prev_mem [NUM_SLABS];

   logic [MW-1:0] rd_mask_ff;
   logic [LW-1:0] rd_next_ff, rd_prev_ff;
   logic [IW-1:0] rd_addr;

   logic          mask_we, next_we, prev_we;
   logic [IW-1:0] mask_wa, next_wa, prev_wa;
   logic [MW-1:0] mask_wd;
   logic [LW-1:0] next_wd, prev_wd;

   // control and payload registers
   state_type                     state_ff, state_in;
   logic [IW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 ipb_ff, ipb_in;
   logic [LW-1:0]                 ph_ff, ph_in, eh_ff, eh_in, fh_ff, fh_in;
   logic [ssa_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ssa_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [IW-1:0]                 s_ff, s_in;
   logic                          bad_ff, bad_in;
   logic                          nosp_ff, nosp_in;
   logic                          use_part_ff, use_part_in;
   logic [LW-1:0]                 mv_nx_ff, mv_nx_in, mv_pv_ff, mv_pv_in, mv_dst_ff, mv_dst_in;
   logic                          mv_head_ff, mv_head_in;
   ssa_pkg::rsp_payload_type      res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ssa_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [CW-1:0]             n_slots;
   logic [MW-1:0]             usable;
   logic [LW-1:0]             s_ext;
   logic [MW-1:0]             bit_k, new_mask;
   logic [ssa_pkg::SLOT_W-1:0] k;
   logic                      do_move, src_head_hit;
   logic [1:0]                src_l, dst_l;
   logic [LW-1:0]             src_head, dst_head;

   function automatic logic [ssa_pkg::SLOT_W-1:0] lowest_set(input logic [MW-1:0] m);
      logic [ssa_pkg::SLOT_W-1:0] r;
      r = ssa_pkg::SLOT_W'(MW - 1);
      for (int i = MW - 1; i >= 0; i--) begin
         if (m[i]) r = ssa_pkg::SLOT_W'(i);
      end
      return r;
   endfunction

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;
   assign s_ext          = {1'b0, s_ff};

   // clamp slot count and build the usable mask
   always_comb begin
      n_slots = ipb_ff;
      if (ipb_ff < CW'(2)) n_slots = CW'(2);
      if (ipb_ff > CW'(MAX_SLOTS)) n_slots = CW'(MAX_SLOTS);
      for (int i = 0; i < MW; i++) usable[i] = (CW'(i) < n_slots);
   end

   // read address while idle: free slab or list head, else the current slab
   always_comb begin
      rd_addr = s_ff;
      if (state_ff == S_IDLE) begin
         if (req_ch.payload.cmd == ssa_pkg::CMD_FREE) begin
            rd_addr = IW'(req_ch.payload.item_slab);
         end else if (ph_ff < NIL) begin
            rd_addr = ph_ff[IW-1:0];
         end else begin
            rd_addr = eh_ff[IW-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ipb_in       = ipb_ff;
      ph_in        = ph_ff;
      eh_in        = eh_ff;
      fh_in        = fh_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      bad_in       = bad_ff;
      nosp_in      = nosp_ff;
      use_part_in  = use_part_ff;
      mv_nx_in     = mv_nx_ff;
      mv_pv_in     = mv_pv_ff;
      mv_dst_in    = mv_dst_ff;
      mv_head_in   = mv_head_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mask_we = 1'b0; mask_wa = s_ff; mask_wd = rd_mask_ff;
      next_we = 1'b0; next_wa = s_ff; next_wd = NIL;
      prev_we = 1'b0; prev_wa = s_ff; prev_wd = NIL;
      bit_k    = '0;
      new_mask = rd_mask_ff;
      k        = '0;
      do_move  = 1'b0;
      src_l    = L_PART;
      dst_l    = L_PART;
      src_head = ph_ff;
      dst_head = ph_ff;
      src_head_hit = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_INIT: begin
            mask_we = 1'b1; mask_wa = cnt_ff; mask_wd = usable;
            next_we = 1'b1; next_wa = cnt_ff; next_wd = LW'(cnt_ff) + LW'(1);
            prev_we = 1'b1; prev_wa = cnt_ff;
            prev_wd = (cnt_ff == '0) ? NIL : LW'(cnt_ff) - LW'(1);
            cnt_in  = cnt_ff + IW'(1);
            if (cnt_ff == IW'(NUM_SLABS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in      = req_ch.payload.cmd;
               slot_in     = req_ch.payload.item_slot;
               s_in        = rd_addr;
               use_part_in = (ph_ff < NIL);
               nosp_in     = !(ph_ff < NIL) && !(eh_ff < NIL);
               bad_in      = !(32'(req_ch.payload.item_slab) < NUM_SLABS) ||
                             !(CW'(req_ch.payload.item_slot) < n_slots);
               state_in    = S_EX;
            end
         end
         S_EX: begin
            res_in   = '0;
            state_in = S_PUT;
            if (cmd_ff == ssa_pkg::CMD_ALLOC) begin
               if (nosp_ff) begin
                  res_in.status = ssa_pkg::STAT_NO_SPACE;
               end else if (use_part_ff) begin
                  k        = lowest_set(rd_mask_ff);
                  bit_k    = MW'(1) << k;
                  new_mask = rd_mask_ff & ~bit_k;
                  mask_we  = 1'b1; mask_wd = new_mask;
                  res_in.got_slab = ssa_pkg::SLAB_W'(s_ff);
                  res_in.got_slot = k;
                  if (new_mask == '0) begin
                     do_move = 1'b1; src_l = L_PART; dst_l = L_FULL;
                  end
               end else begin
                  mask_we = 1'b1; mask_wd = usable & ~MW'(1);
                  res_in.got_slab = ssa_pkg::SLAB_W'(s_ff);
                  do_move = 1'b1; src_l = L_EMPTY; dst_l = L_PART;
               end
            end else begin
               bit_k = MW'(1) << slot_ff;
               if (bad_ff || ((rd_mask_ff & bit_k) != '0)) begin
                  res_in.status = ssa_pkg::STAT_BAD_FREE;
               end else if (rd_mask_ff == '0) begin
                  mask_we = 1'b1; mask_wd = bit_k;
                  do_move = 1'b1; src_l = L_FULL; dst_l = L_PART;
               end else if ((rd_mask_ff | bit_k) == usable) begin
                  mask_we = 1'b1; mask_wd = usable;
                  do_move = 1'b1; src_l = L_PART; dst_l = L_EMPTY;
               end else begin
                  mask_we = 1'b1; mask_wd = rd_mask_ff | bit_k;
               end
            end

            // unlink from source list, push on destination head
            if (do_move) begin
               case (src_l)
                  L_PART:  src_head = ph_ff;
                  L_EMPTY: src_head = eh_ff;
                  default: src_head = fh_ff;
               endcase
               case (dst_l)
                  L_PART:  dst_head = ph_ff;
                  L_EMPTY: dst_head = eh_ff;
                  default: dst_head = fh_ff;
               endcase
               src_head_hit = (src_head == s_ext);
               mv_nx_in   = rd_next_ff;
               mv_pv_in   = rd_prev_ff;
               mv_dst_in  = dst_head;
               mv_head_in = src_head_hit;
               if (src_head_hit) begin
                  case (src_l)
                     L_PART:  ph_in = rd_next_ff;
                     L_EMPTY: eh_in = rd_next_ff;
                     default: fh_in = rd_next_ff;
                  endcase
               end
               case (dst_l)
                  L_PART:  ph_in = s_ext;
                  L_EMPTY: eh_in = s_ext;
                  default: fh_in = s_ext;
               endcase
               next_we = 1'b1; next_wa = s_ff; next_wd = dst_head;
               prev_we = 1'b1; prev_wa = s_ff; prev_wd = NIL;
               state_in = S_W1;
            end
         end
         S_W1: begin
            if (!mv_head_ff && (mv_pv_ff < NIL)) begin
               next_we = 1'b1; next_wa = mv_pv_ff[IW-1:0]; next_wd = mv_nx_ff;
            end
            if (mv_nx_ff < NIL) begin
               prev_we = 1'b1; prev_wa = mv_nx_ff[IW-1:0]; prev_wd = mv_pv_ff;
            end
            state_in = S_W2;
         end
         S_W2: begin
            if (mv_dst_ff < NIL) begin
               prev_we = 1'b1; prev_wa = mv_dst_ff[IW-1:0]; prev_wd = s_ext;
            end
            state_in = S_PUT;
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase

      // register write rebuilds the pool
      if (csr_ch.valid) begin
         ipb_in   = csr_ch.data;
         state_in = S_INIT;
         cnt_in   = '0;
         ph_in    = NIL;
         eh_in    = '0;
         fh_in    = NIL;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         ipb_ff       <= CW'(64);
         ph_ff        <= NIL;
         eh_ff        <= '0;
         fh_ff        <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ipb_ff       <= ipb_in;
         ph_ff        <= ph_in;
         eh_ff        <= eh_in;
         fh_ff        <= fh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      s_ff        <= s_in;
      bad_ff      <= bad_in;
      nosp_ff     <= nosp_in;
      use_part_ff <= use_part_in;
      mv_nx_ff    <= mv_nx_in;
      mv_pv_ff    <= mv_pv_in;
      mv_dst_ff   <= mv_dst_in;
      mv_head_ff  <= mv_head_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // slot bitmaps and link memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (mask_we) mask_mem[mask_wa] <= mask_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      rd_mask_ff <= mask_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
   end

endmodule
